>>> sv/lhs_pkg.sv
package lhs_pkg;

	localparam int POINTS_MAX = 64;
	localparam int IDX_W = 6;
	localparam int CNT_W = 7;
	localparam int DIM_W = 10;
	localparam int SEED_W = 31;
	localparam int COORD_W = 16;
	localparam int DIV_W = 38;

	localparam logic [SEED_W-1:0] PM_MOD = 31'h7FFF_FFFF;
	localparam logic [14:0] PM_MULT = 15'd16807;

	localparam logic [1:0] REG_POINT_COUNT = 2'd0;
	localparam logic [1:0] REG_DIM_COUNT = 2'd1;
	localparam logic [1:0] REG_SEED_INIT = 2'd2;

	typedef struct packed {
		logic load;
		logic step;
		logic [SEED_W-1:0] value;
	} prng_ctl_t;

	typedef struct packed {
		logic start;
		logic [DIV_W-1:0] num;
		logic [DIV_W-1:0] den;
	} div_req_t;

	// A seed of zero or of the modulus would lock the generator.
	function automatic logic [SEED_W-1:0] safe_seed(input logic [SEED_W-1:0] s);
		logic [SEED_W-1:0] r;
		r = s;
		if (s == '0 || s == PM_MOD) begin
			r = SEED_W'(1);
		end
		return r;
	endfunction

endpackage

>>> sv/lhs_prng.sv
module lhs_prng (
	input  logic clk,
	input  logic arst_n,
	input  lhs_pkg::prng_ctl_t ctl,
	output logic [lhs_pkg::SEED_W-1:0] seed
);
	import lhs_pkg::*;

	logic [SEED_W-1:0] seed_q;
	logic [45:0] prod;
	logic [31:0] fold;
	logic [31:0] red;
	logic [SEED_W-1:0] next;

	// Modulo 2^31-1 folds the high bits back onto the low ones.
	always_comb begin
		prod = 46'(seed_q) * 46'(PM_MULT);
		fold = 32'(prod[30:0]) + 32'(prod[45:31]);
		red = (fold >= 32'(PM_MOD)) ? fold - 32'(PM_MOD) : fold;
		next = safe_seed(red[SEED_W-1:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= SEED_W'(1);
		end else if (ctl.load) begin
			seed_q <= safe_seed(ctl.value);
		end else if (ctl.step) begin
			seed_q <= next;
		end
	end

	assign seed = seed_q;
endmodule

>>> sv/lhs_perm_ram.sv
module lhs_perm_ram (
	input  logic clk,
	input  logic wr_en,
	input  logic [lhs_pkg::IDX_W-1:0] wr_addr,
	input  logic [lhs_pkg::IDX_W-1:0] wr_data,
	input  logic [lhs_pkg::IDX_W-1:0] rd_addr_a,
	input  logic [lhs_pkg::IDX_W-1:0] rd_addr_b,
	output logic [lhs_pkg::IDX_W-1:0] rd_data_a,
	output logic [lhs_pkg::IDX_W-1:0] rd_data_b
);
	import lhs_pkg::*;

	logic [IDX_W-1:0] mem_q [POINTS_MAX];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_a <= mem_q[rd_addr_a];
		rd_data_b <= mem_q[rd_addr_b];
	end
endmodule

>>> sv/lhs_divider.sv
module lhs_divider (
	input  logic clk,
	input  logic arst_n,
	input  lhs_pkg::div_req_t req,
	output logic done,
	output logic [lhs_pkg::COORD_W-1:0] quot
);
	import lhs_pkg::*;

	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] den_q;
	logic [COORD_W-1:0] quot_q;
	logic [4:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [DIV_W:0] dbl;
	logic ge;

	// Restoring division, one quotient bit per cycle; num stays below den.
	always_comb begin
		dbl = {rem_q, 1'b0};
		ge = dbl >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(COORD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= ge ? DIV_W'(dbl - {1'b0, den_q}) : dbl[DIV_W-1:0];
			quot_q <= {quot_q[COORD_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;
endmodule

>>> sv/latin_hypercube_sampler.sv
// Channel  | Handshake                 | Payload
// input    | in_valid, in_stall        | restart
// output   | out_valid, out_stall      | dim_index, point_index, cell_res, fraction_raw,
//          |                           | coordinate, last_point, last_dim
// config   | cfg_valid, cfg_ready      | cfg_index, cfg_data
//
// One request fills the permutation, shuffles it, then emits one beat per point;
// the bit-serial coordinate divider takes up most of that time.
// in_stall is high from acceptance until the last beat of the dimension is taken.
// Reset loads seed 1, point_count 64, dim_count 1 and clears the dimension counter.
// A stalled output beat holds; the block waits on it before drawing the next point.
module latin_hypercube_sampler (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic restart,
	output logic out_valid,
	input  logic out_stall,
	output logic [9:0] dim_index,
	output logic [5:0] point_index,
	output logic [5:0] cell_res,
	output logic [30:0] fraction_raw,
	output logic [15:0] coordinate,
	output logic last_point,
	output logic last_dim,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [30:0] cfg_data
);
	import lhs_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_FILL = 4'd1;
	localparam logic [3:0] ST_DRAW = 4'd2;
	localparam logic [3:0] ST_OFF = 4'd3;
	localparam logic [3:0] ST_SWA = 4'd4;
	localparam logic [3:0] ST_SWB = 4'd5;
	localparam logic [3:0] ST_DRAW2 = 4'd6;
	localparam logic [3:0] ST_PREP = 4'd7;
	localparam logic [3:0] ST_DIV = 4'd8;
	localparam logic [3:0] ST_OUT = 4'd9;

	logic [3:0] state_q;
	logic [CNT_W-1:0] point_count_q;
	logic [10:0] dim_count_q;
	logic [SEED_W-1:0] seed_init_q;
	logic [DIM_W-1:0] dim_q;
	logic [CNT_W-1:0] n_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] swap_q;
	logic [IDX_W-1:0] cell_q;
	logic last_dim_q;
	logic out_valid_q;

	logic [CNT_W-1:0] n_eff;
	logic [10:0] dims_eff;
	logic [DIM_W-1:0] dim_start;
	logic accept;
	logic idx_last;

	prng_ctl_t prng_ctl;
	logic [SEED_W-1:0] seed;
	div_req_t div_req;
	logic div_done;
	logic [COORD_W-1:0] div_quot;

	logic wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [IDX_W-1:0] wr_data;
	logic [IDX_W-1:0] rd_addr_b;
	logic [IDX_W-1:0] rd_data_a;
	logic [IDX_W-1:0] rd_data_b;

	logic [CNT_W-1:0] span;
	logic [37:0] prod;
	logic [31:0] fold;
	logic [CNT_W-1:0] off;
	logic [CNT_W-1:0] off_max;

	assign accept = in_valid && (state_q == ST_IDLE);
	assign in_stall = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign idx_last = ({1'b0, idx_q} == n_q - CNT_W'(1));

	always_comb begin
		n_eff = point_count_q;
		if (point_count_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (point_count_q > CNT_W'(POINTS_MAX)) begin
			n_eff = CNT_W'(POINTS_MAX);
		end
		dims_eff = dim_count_q;
		if (dim_count_q == '0) begin
			dims_eff = 11'd1;
		end else if (dim_count_q > 11'd1024) begin
			dims_eff = 11'd1024;
		end
		dim_start = restart ? '0 : dim_q;
	end

	// Swap offset floor(raw*span/(2^31-1)), folded like the generator's modulo.
	always_comb begin
		span = n_q - CNT_W'(idx_q);
		prod = 38'(seed) * 38'(span);
		fold = 32'(prod[30:0]) + 32'(prod[37:31]);
		off = prod[37:31] + ((fold >= 32'(PM_MOD)) ? CNT_W'(1) : CNT_W'(0));
		off_max = span - CNT_W'(1);
		if (off > off_max) begin
			off = off_max;
		end
		rd_addr_b = idx_q + off[IDX_W-1:0];
	end

	always_comb begin
		prng_ctl.load = accept && restart;
		prng_ctl.value = seed_init_q;
		prng_ctl.step = (state_q == ST_DRAW) || (state_q == ST_DRAW2);
		div_req.start = (state_q == ST_PREP);
		div_req.num = ({rd_data_a, 32'b0} >> 1) - DIV_W'(rd_data_a) + DIV_W'(seed);
		div_req.den = ({n_q, 31'b0}) - DIV_W'(n_q);
		wr_en = 1'b0;
		wr_addr = idx_q;
		wr_data = idx_q;
		case (state_q)
			ST_FILL: begin
				wr_en = 1'b1;
			end
			ST_SWA: begin
				wr_en = 1'b1;
				wr_data = rd_data_b;
			end
			ST_SWB: begin
				wr_en = 1'b1;
				wr_addr = swap_q;
				wr_data = rd_data_a;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	lhs_prng u_prng (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(prng_ctl),
		.seed(seed)
	);

	lhs_perm_ram u_perm (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr_a(idx_q),
		.rd_addr_b(rd_addr_b),
		.rd_data_a(rd_data_a),
		.rd_data_b(rd_data_b)
	);

	lhs_divider u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.done(div_done),
		.quot(div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= CNT_W'(64);
			dim_count_q <= 11'd1;
			seed_init_q <= SEED_W'(1);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_POINT_COUNT: point_count_q <= cfg_data[CNT_W-1:0];
				REG_DIM_COUNT: dim_count_q <= cfg_data[10:0];
				REG_SEED_INIT: seed_init_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			dim_q <= '0;
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						dim_q <= dim_start;
						idx_q <= '0;
						state_q <= ST_FILL;
					end
				end
				ST_FILL: begin
					if (idx_last) begin
						idx_q <= '0;
						state_q <= ST_DRAW;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_DRAW: state_q <= ST_OFF;
				ST_OFF: state_q <= ST_SWA;
				ST_SWA: state_q <= ST_SWB;
				ST_SWB: begin
					if (idx_last) begin
						idx_q <= '0;
						state_q <= ST_DRAW2;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
						state_q <= ST_DRAW;
					end
				end
				ST_DRAW2: state_q <= ST_PREP;
				ST_PREP: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done) begin
						out_valid_q <= 1'b1;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_stall) begin
						out_valid_q <= 1'b0;
						if (idx_last) begin
							dim_q <= last_dim_q ? '0 : dim_q + DIM_W'(1);
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + IDX_W'(1);
							state_q <= ST_DRAW2;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			n_q <= n_eff;
			last_dim_q <= (11'(dim_start) >= dims_eff - 11'd1);
		end
		if (state_q == ST_OFF) begin
			swap_q <= rd_addr_b;
		end
		if (state_q == ST_PREP) begin
			cell_q <= rd_data_a;
		end
	end

	assign out_valid = out_valid_q;
	assign dim_index = dim_q;
	assign point_index = idx_q;
	assign cell_res = cell_q;
	assign fraction_raw = seed;
	assign coordinate = div_quot;
	assign last_point = idx_last;
	assign last_dim = last_dim_q;
endmodule
